[design/ccl_pkg.sv]
// Shared widths, coherence state, message, action and event codes for line control.
package ccl_pkg;

    localparam int LINES   = 1024;
    localparam int LINE_W  = $clog2(LINES);
    localparam int STATE_W = 3;
    localparam int OP_W    = 4;
    localparam int ACT_W   = 3;
    localparam int EV_W    = 3;
    localparam int NODE_W  = 4;
    localparam int ADDR_W  = 32;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [OP_W-1:0]    t_op;
    typedef logic [ACT_W-1:0]   t_act;
    typedef logic [EV_W-1:0]    t_event;

    // line states
    localparam t_state ST_I  = 3'd0;
    localparam t_state ST_S  = 3'd1;
    localparam t_state ST_O  = 3'd2;
    localparam t_state ST_M  = 3'd3;
    localparam t_state ST_F  = 3'd4;
    localparam t_state ST_IM = 3'd5;
    localparam t_state ST_IP = 3'd6;

    // message kinds
    localparam t_op OP_LOAD  = 4'd0;
    localparam t_op OP_STORE = 4'd1;
    localparam t_op OP_GETS  = 4'd2;
    localparam t_op OP_GETM  = 4'd3;
    localparam t_op OP_DATA  = 4'd4;
    localparam t_op OP_DATAF = 4'd5;
    localparam t_op OP_INV   = 4'd6;
    localparam t_op OP_INVDS = 4'd7;
    localparam t_op OP_ACK   = 4'd8;

    // reply actions
    localparam t_act ACT_NONE  = 3'd0;
    localparam t_act ACT_PROC  = 3'd1;
    localparam t_act ACT_GETS  = 3'd2;
    localparam t_act ACT_GETM  = 3'd3;
    localparam t_act ACT_DATA  = 3'd4;
    localparam t_act ACT_ACK   = 3'd5;
    localparam t_act ACT_NOP   = 3'd6;
    localparam t_act ACT_RETRY = 3'd7;

    // hit/miss events
    localparam t_event EV_NONE     = 3'd0;
    localparam t_event EV_RD_HIT   = 3'd1;
    localparam t_event EV_RD_MISS  = 3'd2;
    localparam t_event EV_WR_HIT   = 3'd3;
    localparam t_event EV_WR_UPGR  = 3'd4;
    localparam t_event EV_WR_MISS  = 3'd5;

endpackage

[design/ccl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ccl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/cache_coherence_line_controller.sv]
// Snooping coherence line controller: state table read-modify-write per message word.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | input     | i_in_valid / o_in_stall   | op, line_index, address, source_node
//   out     | output    | o_out_valid / i_out_stall | action, reply_address, dest_node,
//           |           |                           | event_code, protocol_error
//
// Each word has a state table read step, then a decode and write-back step.
// The table has one read and one write port, and a new word is taken only after the
// previous one has written its line back, so same-line hazards cannot arise.
// After reset a clearing pass writes state I to all 1024 lines; o_in_stall
// is high meanwhile. The result register holds a finished word while the output stalls;
// a word in decode then waits until that register frees up.
module cache_coherence_line_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ccl_pkg::OP_W-1:0]    i_op,
    input  logic [ccl_pkg::LINE_W-1:0]  i_line_index,
    input  logic [ccl_pkg::ADDR_W-1:0]  i_address,
    input  logic [ccl_pkg::NODE_W-1:0]  i_source_node,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ccl_pkg::ACT_W-1:0]   o_action,
    output logic [ccl_pkg::ADDR_W-1:0]  o_reply_address,
    output logic [ccl_pkg::NODE_W-1:0]  o_dest_node,
    output logic [ccl_pkg::EV_W-1:0]    o_event_code,
    output logic                        o_protocol_error
);

    // control
    logic                        r_clr_done;
    logic [ccl_pkg::LINE_W-1:0]  r_clr_idx;
    logic                        r_busy;
    logic                        r_out_valid;

    // captured word
    ccl_pkg::t_op                r_op;
    logic [ccl_pkg::LINE_W-1:0]  r_idx;
    logic [ccl_pkg::ADDR_W-1:0]  r_addr;
    logic [ccl_pkg::NODE_W-1:0]  r_src;

    // result register
    ccl_pkg::t_act               r_action;
    logic [ccl_pkg::ADDR_W-1:0]  r_reply_address;
    logic [ccl_pkg::NODE_W-1:0]  r_dest_node;
    ccl_pkg::t_event             r_event_code;
    logic                        r_protocol_error;

    logic                        in_accept;
    logic                        finish;
    ccl_pkg::t_state             st;
    ccl_pkg::t_state             nx;
    ccl_pkg::t_act               act;
    ccl_pkg::t_event             ev;
    logic                        err;
    logic                        ram_we;
    logic [ccl_pkg::LINE_W-1:0]  ram_waddr;
    ccl_pkg::t_state             ram_wdata;

    assign o_in_stall = !r_clr_done || r_busy;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign finish     = r_busy && (!r_out_valid || !i_out_stall);

    assign ram_we    = !r_clr_done || finish;
    assign ram_waddr = r_clr_done ? r_idx : r_clr_idx;
    assign ram_wdata = r_clr_done ? nx : ccl_pkg::ST_I;

    ccl_ram #(
        .WIDTH (ccl_pkg::STATE_W),
        .DEPTH (ccl_pkg::LINES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_line_index),
        .o_rdata (st)
    );

    // protocol decode
    always_comb begin
        nx  = st;
        act = ccl_pkg::ACT_NONE;
        ev  = ccl_pkg::EV_NONE;
        err = 1'b0;
        if (r_op == ccl_pkg::OP_LOAD || r_op == ccl_pkg::OP_STORE) begin
            unique case (st)
                ccl_pkg::ST_I: begin
                    if (r_op == ccl_pkg::OP_LOAD) begin
                        act = ccl_pkg::ACT_GETS;
                        ev  = ccl_pkg::EV_RD_MISS;
                        nx  = ccl_pkg::ST_IP;
                    end else begin
                        act = ccl_pkg::ACT_GETM;
                        ev  = ccl_pkg::EV_WR_MISS;
                        nx  = ccl_pkg::ST_IM;
                    end
                end
                ccl_pkg::ST_S, ccl_pkg::ST_O, ccl_pkg::ST_F: begin
                    if (r_op == ccl_pkg::OP_LOAD) begin
                        act = ccl_pkg::ACT_PROC;
                        ev  = ccl_pkg::EV_RD_HIT;
                    end else begin
                        act = ccl_pkg::ACT_GETM;
                        ev  = ccl_pkg::EV_WR_UPGR;
                        nx  = ccl_pkg::ST_IM;
                    end
                end
                ccl_pkg::ST_M: begin
                    act = ccl_pkg::ACT_PROC;
                    ev  = (r_op == ccl_pkg::OP_LOAD) ? ccl_pkg::EV_RD_HIT : ccl_pkg::EV_WR_HIT;
                end
                default: err = 1'b1;
            endcase
        end else if (r_op > ccl_pkg::OP_ACK) begin
            err = 1'b1;
        end else begin
            unique case (st)
                ccl_pkg::ST_I: begin
                    if (r_op != ccl_pkg::OP_INVDS && r_op != ccl_pkg::OP_ACK) begin
                        err = 1'b1;
                    end
                end
                ccl_pkg::ST_S: begin
                    if (r_op == ccl_pkg::OP_INV) begin
                        act = ccl_pkg::ACT_ACK;
                        nx  = ccl_pkg::ST_I;
                    end else if (r_op == ccl_pkg::OP_INVDS) begin
                        act = ccl_pkg::ACT_NOP;
                        nx  = ccl_pkg::ST_I;
                    end else begin
                        err = 1'b1;
                    end
                end
                ccl_pkg::ST_O, ccl_pkg::ST_F: begin
                    unique case (r_op)
                        ccl_pkg::OP_GETS: act = ccl_pkg::ACT_DATA;
                        ccl_pkg::OP_GETM: begin
                            act = ccl_pkg::ACT_DATA;
                            nx  = ccl_pkg::ST_I;
                        end
                        ccl_pkg::OP_INV: begin
                            act = ccl_pkg::ACT_ACK;
                            nx  = ccl_pkg::ST_I;
                        end
                        ccl_pkg::OP_INVDS: begin
                            act = ccl_pkg::ACT_NOP;
                            nx  = ccl_pkg::ST_I;
                        end
                        ccl_pkg::OP_ACK: ;
                        default: err = 1'b1;
                    endcase
                end
                ccl_pkg::ST_M: begin
                    unique case (r_op)
                        ccl_pkg::OP_GETS: begin
                            act = ccl_pkg::ACT_DATA;
                            nx  = ccl_pkg::ST_O;
                        end
                        ccl_pkg::OP_GETM, ccl_pkg::OP_INV: begin
                            act = ccl_pkg::ACT_DATA;
                            nx  = ccl_pkg::ST_I;
                        end
                        ccl_pkg::OP_INVDS, ccl_pkg::OP_ACK: ;
                        default: err = 1'b1;
                    endcase
                end
                ccl_pkg::ST_IM: begin
                    // GETS while waiting for write permission still supplies data
                    unique case (r_op)
                        ccl_pkg::OP_GETS:  act = ccl_pkg::ACT_DATA;
                        ccl_pkg::OP_GETM:  act = ccl_pkg::ACT_RETRY;
                        ccl_pkg::OP_DATA, ccl_pkg::OP_ACK: begin
                            act = ccl_pkg::ACT_PROC;
                            nx  = ccl_pkg::ST_M;
                        end
                        ccl_pkg::OP_INV:   act = ccl_pkg::ACT_ACK;
                        ccl_pkg::OP_INVDS: act = ccl_pkg::ACT_NOP;
                        default: err = 1'b1;
                    endcase
                end
                ccl_pkg::ST_IP: begin
                    unique case (r_op)
                        ccl_pkg::OP_GETS: act = ccl_pkg::ACT_DATA;
                        ccl_pkg::OP_GETM, ccl_pkg::OP_INV: act = ccl_pkg::ACT_RETRY;
                        ccl_pkg::OP_DATA: begin
                            act = ccl_pkg::ACT_PROC;
                            nx  = ccl_pkg::ST_S;
                        end
                        ccl_pkg::OP_DATAF: begin
                            act = ccl_pkg::ACT_PROC;
                            nx  = ccl_pkg::ST_F;
                        end
                        default: err = 1'b1;
                    endcase
                end
                default: err = 1'b1;
            endcase
        end
        // illegal message leaves the line as it was
        if (err) begin
            nx  = st;
            act = ccl_pkg::ACT_NONE;
            ev  = ccl_pkg::EV_NONE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done  <= 1'b0;
            r_clr_idx   <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_clr_done) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == ccl_pkg::LINE_W'(ccl_pkg::LINES - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word capture and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_op;
            r_idx  <= i_line_index;
            r_addr <= i_address;
            r_src  <= i_source_node;
        end
        if (finish) begin
            r_action         <= act;
            r_reply_address  <= (act == ccl_pkg::ACT_NONE) ? '0 : r_addr;
            r_dest_node      <= (act == ccl_pkg::ACT_DATA || act == ccl_pkg::ACT_ACK ||
                                 act == ccl_pkg::ACT_NOP) ? r_src : '0;
            r_event_code     <= ev;
            r_protocol_error <= err;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_action;
    assign o_reply_address  = r_reply_address;
    assign o_dest_node      = r_dest_node;
    assign o_event_code     = r_event_code;
    assign o_protocol_error = r_protocol_error;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> r_clr_done)
        else $error("word accepted during table clear");

    a_table_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_clr_done) |-> r_busy)
        else $error("table written with no word in decode");

    a_error_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_protocol_error) |->
            (o_action == ccl_pkg::ACT_NONE && o_event_code == ccl_pkg::EV_NONE &&
             o_reply_address == '0 && o_dest_node == '0))
        else $error("error result carries a reply");

    a_finish_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (o_out_valid && !r_busy))
        else $error("finished word did not reach the result register");

    a_bus_event_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_op != ccl_pkg::OP_LOAD && r_op != ccl_pkg::OP_STORE) |=>
            (o_event_code == ccl_pkg::EV_NONE))
        else $error("bus message produced a hit/miss event");
`endif

endmodule
